// ----- hdl/clfe_pkg.sv -----
// Shared types and constants for the chunked lite frame encoder.
// No dependencies; imported by the front end, command queue, back end and top level.
`default_nettype none

package clfe_pkg;

  // Default frame geometry
  localparam int MAX_PAYLOAD_DEFAULT = 32;
  localparam int CHUNK_LIMIT_DEFAULT = 16;

  // Command queue between front and back
  localparam int CMD_DEPTH = 4;

  // Sequence byte low nibble mask
  localparam logic [3:0] SEQ_NIBBLE_MASK = 4'hF;

  // One classified input byte, as handed from front to back
  typedef struct packed {
    logic       reject;        // error result only
    logic       open_frame;    // emit start byte and frame header first
    logic       first_matrix;  // header carries rows and cols
    logic       close_frame;   // emit checksum after the data byte
    logic       last_of_msg;   // this byte ends the message
    logic [7:0] data;
    logic [7:0] id;
    logic [7:0] ts_code;
    logic [7:0] seq;
    logic [7:0] len;
    logic [7:0] rows;
    logic [7:0] cols;
  } cmd_t;

endpackage

`default_nettype wire

// ----- hdl/clfe_front.sv -----
// Front end: tracks message and frame position and classifies each input byte.
// Depends on clfe_pkg (cmd_t).
`default_nettype none

module clfe_front import clfe_pkg::*; #(
  parameter int MaxPayload = MAX_PAYLOAD_DEFAULT,
  parameter int ChunkLimit = CHUNK_LIMIT_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  variable_id,
  input  logic [7:0]  type_and_shape,
  input  logic [15:0] message_length,
  input  logic        matrix_mode,
  input  logic [7:0]  row_count,
  input  logic [7:0]  column_count,
  output cmd_t        cmd
);

  localparam int RejPlain  = ChunkLimit * MaxPayload;
  localparam int RejMatrix = RejPlain - 2;

  // message state
  logic [15:0] msg_pos;
  logic [7:0]  frame_pos;
  logic [3:0]  chunk_idx;
  logic [4:0]  chunk_total;
  logic        rej_flag;
  logic [7:0]  frame_size;
  logic [7:0]  hdr_id, hdr_ts, hdr_rows, hdr_cols;
  logic [15:0] hdr_len;
  logic        hdr_mat;

  // effective values for this byte
  logic        first;
  logic [7:0]  e_id, e_ts, e_rows, e_cols;
  logic [15:0] e_len;
  logic        e_mat;
  logic [ChunkLimit-1:0] above;
  logic [4:0]  count;
  logic        rej_new, e_rej;
  logic [4:0]  e_total;
  logic [7:0]  e_fp;
  logic [3:0]  e_chunk;
  logic [15:0] pos_inc, remain;
  logic        open_f, first_mat, close_f, last_f;
  logic [7:0]  cap, fsize_new, e_fsize;

  // header is taken from the ports on the first byte of a message
  always_comb begin
    first  = (msg_pos == 16'd0);
    e_id   = first ? variable_id    : hdr_id;
    e_ts   = first ? type_and_shape : hdr_ts;
    e_len  = first ? message_length : hdr_len;
    e_mat  = first ? matrix_mode    : hdr_mat;
    e_rows = first ? row_count      : hdr_rows;
    e_cols = first ? column_count   : hdr_cols;
  end

  // chunk count by comparing the length against each frame boundary
  always_comb begin
    for (int j = 0; j < ChunkLimit; j++) begin
      above[j] = e_len > (16'(j * MaxPayload) + (e_mat ? 16'(MaxPayload - 2) : 16'd0));
    end
    count   = 5'($countones(above)) + {4'd0, e_mat};
    rej_new = (e_len == 16'd0) ||
              (e_mat ? (e_len > 16'(RejMatrix)) : (e_len > 16'(RejPlain)));
  end

  // frame classification
  always_comb begin
    e_rej     = first ? rej_new : rej_flag;
    e_total   = first ? count : chunk_total;
    e_fp      = first ? 8'd0 : frame_pos;
    e_chunk   = first ? 4'd0 : chunk_idx;
    pos_inc   = msg_pos + 16'd1;
    open_f    = (e_fp == 8'd0);
    first_mat = e_mat && (e_chunk == 4'd0);
    remain    = e_len - msg_pos;
    cap       = first_mat ? 8'(MaxPayload - 2) : 8'(MaxPayload);
    fsize_new = (remain > {8'd0, cap}) ? cap : remain[7:0];
    e_fsize   = open_f ? fsize_new : frame_size;
    close_f   = ({1'b0, e_fp} + 9'd1) >= {1'b0, e_fsize};
    last_f    = e_rej ? ((e_len == 16'd0) || (pos_inc == e_len)) : (pos_inc == e_len);
  end

  // command to the back end
  always_comb begin
    cmd.reject       = e_rej;
    cmd.open_frame   = open_f;
    cmd.first_matrix = first_mat;
    cmd.close_frame  = close_f;
    cmd.last_of_msg  = last_f;
    cmd.data         = data_byte;
    cmd.id           = e_id;
    cmd.ts_code      = e_ts;
    cmd.seq          = {e_chunk, 4'(e_total - 5'd1) & SEQ_NIBBLE_MASK};
    cmd.len          = fsize_new + (first_mat ? 8'd2 : 8'd0);
    cmd.rows         = e_rows;
    cmd.cols         = e_cols;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      msg_pos     <= '0;
      frame_pos   <= '0;
      chunk_idx   <= '0;
      chunk_total <= '0;
      rej_flag    <= 1'b0;
    end else if (take) begin
      msg_pos     <= last_f ? 16'd0 : pos_inc;
      rej_flag    <= e_rej && !last_f;
      chunk_total <= e_total;
      frame_pos   <= (e_rej || close_f || last_f) ? 8'd0 : e_fp + 8'd1;
      if (e_rej || last_f) begin
        chunk_idx <= 4'd0;
      end else if (close_f) begin
        chunk_idx <= e_chunk + 4'd1;
      end else begin
        chunk_idx <= e_chunk;
      end
    end
  end

  // latched header and open frame size
  always_ff @(posedge clk) begin
    if (take) begin
      if (first) begin
        hdr_id   <= variable_id;
        hdr_ts   <= type_and_shape;
        hdr_len  <= message_length;
        hdr_mat  <= matrix_mode;
        hdr_rows <= row_count;
        hdr_cols <= column_count;
      end
      frame_size <= e_fsize;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/clfe_cmd_fifo.sv -----
// Short command queue decoupling the front end from the back end.
// Depends on clfe_pkg (cmd_t, CMD_DEPTH).
`default_nettype none

module clfe_cmd_fifo import clfe_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  cmd_t wr_cmd,
  input  logic rd,
  output cmd_t rd_cmd,
  output logic full,
  output logic empty
);

  localparam int PtrW = $clog2(CMD_DEPTH);

  cmd_t              entries [CMD_DEPTH];
  logic [PtrW-1:0]   wr_ptr, rd_ptr;
  logic [PtrW:0]     fill;

  assign full   = (fill == (PtrW+1)'(CMD_DEPTH));
  assign empty  = (fill == '0);
  assign rd_cmd = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + PtrW'(1);
      if (rd) rd_ptr <= rd_ptr + PtrW'(1);
      fill <= fill + (PtrW+1)'(wr) - (PtrW+1)'(rd);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr) entries[wr_ptr] <= wr_cmd;
  end

endmodule

`default_nettype wire

// ----- hdl/clfe_back.sv -----
// Back end: walks each command through its frame bytes, one byte per cycle while
// the output is not stalled, into a single output register. Depends on clfe_pkg (cmd_t).
`default_nettype none

module clfe_back import clfe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] start_byte,
  input  cmd_t       q_cmd,
  input  logic       q_empty,
  output logic       q_pop,
  input  logic       out_pop,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       frame_end,
  output logic       message_end,
  output logic       run_last,
  output logic       status
);

  typedef enum logic [9:0] {
    PH_START = 10'b00_0000_0001,
    PH_ID    = 10'b00_0000_0010,
    PH_TS    = 10'b00_0000_0100,
    PH_SEQ   = 10'b00_0000_1000,
    PH_LEN   = 10'b00_0001_0000,
    PH_ROWS  = 10'b00_0010_0000,
    PH_COLS  = 10'b00_0100_0000,
    PH_DATA  = 10'b00_1000_0000,
    PH_CSUM  = 10'b01_0000_0000,
    PH_REJ   = 10'b10_0000_0000
  } phase_t;

  cmd_t       cur;
  logic       cur_valid;
  phase_t     phase, phase_after, phase_init;
  logic [7:0] csum;
  logic [7:0] b;
  logic       step_last, fe, me, st;
  logic       advance, load;

  // first phase of the waiting command
  always_comb begin
    priority if (q_cmd.reject) begin
      phase_init = PH_REJ;
    end else if (q_cmd.open_frame) begin
      phase_init = PH_START;
    end else begin
      phase_init = PH_DATA;
    end
  end

  // byte and flags for the current phase
  always_comb begin
    b           = 8'd0;
    fe          = 1'b0;
    me          = 1'b0;
    st          = 1'b0;
    step_last   = 1'b0;
    phase_after = PH_START;
    unique case (phase)
      PH_START: begin b = start_byte;     phase_after = PH_ID;  end
      PH_ID:    begin b = cur.id;         phase_after = PH_TS;  end
      PH_TS:    begin b = cur.ts_code;    phase_after = PH_SEQ; end
      PH_SEQ:   begin b = cur.seq;        phase_after = PH_LEN; end
      PH_LEN: begin
        b           = cur.len;
        phase_after = cur.first_matrix ? PH_ROWS : PH_DATA;
      end
      PH_ROWS:  begin b = cur.rows;       phase_after = PH_COLS; end
      PH_COLS:  begin b = cur.cols;       phase_after = PH_DATA; end
      PH_DATA: begin
        b           = cur.data;
        phase_after = PH_CSUM;
        step_last   = !cur.close_frame;
        me          = cur.last_of_msg && !cur.close_frame;
      end
      PH_CSUM: begin
        b         = csum;
        fe        = 1'b1;
        me        = cur.last_of_msg;
        step_last = 1'b1;
      end
      PH_REJ: begin
        st        = 1'b1;
        me        = cur.last_of_msg;
        step_last = 1'b1;
      end
      default: begin
        step_last = 1'b1;
      end
    endcase
  end

  assign advance = cur_valid && (!out_valid || out_pop);
  assign load    = !cur_valid || (advance && step_last);
  assign q_pop   = load && !q_empty;

  // command register and phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      phase     <= PH_START;
    end else if (load) begin
      cur_valid <= !q_empty;
      phase     <= phase_init;
    end else if (advance) begin
      phase     <= phase_after;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_cmd;
  end

  // running checksum over everything after the start byte
  always_ff @(posedge clk) begin
    if (advance) begin
      if (phase == PH_START) begin
        csum <= 8'd0;
      end else begin
        csum <= csum ^ b;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte    <= b;
      frame_end   <= fe;
      message_end <= me;
      run_last    <= step_last;
      status      <= st;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/chunked_lite_frame_encoder.sv -----
// Chunked lite frame encoder, top level.
// Depends on clfe_pkg, clfe_front, clfe_cmd_fifo and clfe_back.
//
//  Channel   Handshake          Payload
//  input     push / full        data_byte, variable_id, type_and_shape,
//                               message_length, matrix_mode, row_count, column_count
//  result    empty / pop        out_byte, frame_end, message_end, run_last, status
//  config    cfg_write          cfg_data (start byte)
//
// An input byte is accepted whenever the command queue has room.
// Each byte yields 1 to 9 result bytes; the back end emits one result byte per
// cycle while the output is not stalled. An accepted byte passes through the
// command queue, the command register and the output register. Reset is synchronous and
// needs no clearing pass. Either side may stall; the queue absorbs up to four
// items and the output register holds a result until it is popped.
`default_nettype none

module chunked_lite_frame_encoder import clfe_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT,
  parameter int CHUNK_LIMIT = CHUNK_LIMIT_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  variable_id,
  input  logic [7:0]  type_and_shape,
  input  logic [15:0] message_length,
  input  logic        matrix_mode,
  input  logic [7:0]  row_count,
  input  logic [7:0]  column_count,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        frame_end,
  output logic        message_end,
  output logic        run_last,
  output logic        status,
  input  logic        cfg_write,
  input  logic [7:0]  cfg_data
);

  cmd_t       f_cmd, q_cmd;
  logic       take, q_pop, q_empty, out_valid;
  logic [7:0] start_byte;

  assign take  = push && !full;
  assign empty = !out_valid;

  // start byte register
  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= 8'hA5;
    end else if (cfg_write) begin
      start_byte <= cfg_data;
    end
  end

  clfe_front #(
    .MaxPayload (MAX_PAYLOAD),
    .ChunkLimit (CHUNK_LIMIT)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .data_byte      (data_byte),
    .variable_id    (variable_id),
    .type_and_shape (type_and_shape),
    .message_length (message_length),
    .matrix_mode    (matrix_mode),
    .row_count      (row_count),
    .column_count   (column_count),
    .cmd            (f_cmd)
  );

  clfe_cmd_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr     (take),
    .wr_cmd (f_cmd),
    .rd     (q_pop),
    .rd_cmd (q_cmd),
    .full   (full),
    .empty  (q_empty)
  );

  clfe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .start_byte  (start_byte),
    .q_cmd       (q_cmd),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .out_pop     (pop),
    .out_valid   (out_valid),
    .out_byte    (out_byte),
    .frame_end   (frame_end),
    .message_end (message_end),
    .run_last    (run_last),
    .status      (status)
  );

endmodule

`default_nettype wire

// ----- hdl/clfe_checker.sv -----
// Port-level checks for the chunked lite frame encoder, bound to the top level.
// Depends on chunked_lite_frame_encoder being compiled first.
`default_nettype none

module clfe_checker (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       frame_end,
  input logic       message_end,
  input logic       run_last,
  input logic       status
);

  // a rejected transaction carries no wire byte and ends its item
  a_reject_shape: assert property (@(posedge clk) disable iff (rst)
    (!empty && status) |-> (out_byte == 8'd0 && !frame_end && run_last))
    else $error("rejected result with wire content");

  // the checksum byte always ends the item's run
  a_csum_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && frame_end) |-> run_last)
    else $error("frame end without run_last");

  // message end is always the last result of its item
  a_msg_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && message_end) |-> run_last)
    else $error("message end without run_last");

  // nothing waits right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result visible after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(status)))
    else $error("stalled result changed");

endmodule

bind chunked_lite_frame_encoder clfe_checker u_clfe_checker (.*);

`default_nettype wire
